@@ rtl/paa_pkg.sv @@
// Shared types and constants of the plane azimuth angle pipeline.
// No dependencies; every other file imports this package.
package paa_pkg;

	// scaled normal component width (magnitude held to 29 bits)
	localparam int NORM_BITS = 29;
	localparam int NRM_W     = NORM_BITS + 1;
	// pre-shifted photon component width
	localparam int G_W       = 29;
	// angle operands after the common scaling
	localparam int OPER_BITS = 30;
	localparam int OPR_W     = OPER_BITS + 1;
	// sum of squares and its root
	localparam int SQ_W      = 62;
	localparam int ROOT_W    = SQ_W / 2;
	// rotation unit data widths
	localparam int CRD_W     = 35;
	localparam int Z_W       = 34;
	localparam int CORDIC_STEPS = 30;
	localparam int PHI_W     = 17;

	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint PI_Q30      = 64'sd3373259426;

	// arctangent of 2^-i in Q30
	localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
		32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
		32'd33543515,  32'd16775850,  32'd8388437,   32'd4194282,   32'd2097149,
		32'd1048575,   32'd524287,    32'd262143,    32'd131071,    32'd65535,
		32'd32767,     32'd16383,     32'd8191,      32'd4095,      32'd2047,
		32'd1023,      32'd511,       32'd255,       32'd127,       32'd63,
		32'd31,        32'd15,        32'd8,         32'd4,         32'd2
	};

	// control that travels with each request through the pipeline
	typedef struct packed {
		logic valid;
		logic zero;
		logic neg;
	} ctl_t;

endpackage

@@ rtl/paa_front.sv @@
// Front end: pre-shift, both plane normals as cross products, normal scaling.
// Six register stages. Depends on paa_pkg.
module paa_front
	import paa_pkg::*;
#(
	parameter int COMP_WIDTH = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         sim_mode,
	input  logic                         valid_i,
	input  logic signed [COMP_WIDTH-1:0] in_v   [3],
	input  logic signed [COMP_WIDTH-1:0] out_v  [3],
	input  logic signed [COMP_WIDTH-1:0] prot_v [3],
	input  logic signed [COMP_WIDTH-1:0] phot_v [3],
	output ctl_t                         ctl_o,
	output logic signed [NRM_W-1:0]      n1_o   [3],
	output logic signed [NRM_W-1:0]      n2_o   [3],
	output logic signed [G_W-1:0]        g_o    [3]
);

	localparam int PS   = (COMP_WIDTH > 29) ? COMP_WIDTH - 29 : 0;
	localparam int EW   = COMP_WIDTH + 1;
	localparam int QW   = EW - PS;
	localparam int PW   = 2 * QW;
	localparam int NW   = PW + 1;
	localparam int BLW  = $clog2(NW + 1);

	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;

	logic signed [QW-1:0]  q_s1 [3], l_s1 [3], g_s1 [3], p_s1 [3];
	logic signed [PW-1:0]  pa_s2 [6], pb_s2 [6];
	logic signed [NW-1:0]  n1_s3 [3], n2_s3 [3];
	logic signed [NW-1:0]  n1_s4 [3], n2_s4 [3];
	logic        [NW-1:0]  m1_s4, m2_s4;
	logic signed [NW-1:0]  n1_s5 [3], n2_s5 [3];
	logic        [BLW-1:0] b1_s5, b2_s5;
	logic signed [NRM_W-1:0] n1_s6 [3], n2_s6 [3];
	logic signed [G_W-1:0] g_s2 [3], g_s3 [3], g_s4 [3], g_s5 [3], g_s6 [3];

	logic signed [EW-1:0]  dif [3], lv [3];
	logic signed [QW-1:0]  q_n [3], l_n [3], g_n [3], p_n [3];
	logic signed [PW-1:0]  pa_n [6], pb_n [6];
	logic signed [NW-1:0]  n1_n [3], n2_n [3];
	logic        [NW-1:0]  m1_n, m2_n, a1, a2;
	logic        [BLW-1:0] b1_n, b2_n;
	logic signed [NW-1:0]  t1, t2;
	logic signed [NRM_W-1:0] n1_sc [3], n2_sc [3];

	// pre-shift the momentum vectors
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dif[i] = EW'(in_v[i]) - EW'(out_v[i]);
			lv[i]  = sim_mode ? -EW'(in_v[i]) : EW'(in_v[i]);
			q_n[i] = QW'(dif[i] >>> PS);
			l_n[i] = QW'(lv[i] >>> PS);
			g_n[i] = QW'(phot_v[i] >>> PS);
			p_n[i] = QW'(prot_v[i] >>> PS);
		end
	end

	// form the cross product terms: n1 = q x l, n2 = g x p
	always_comb begin
		pa_n[0] = q_s1[1] * l_s1[2];
		pa_n[1] = q_s1[2] * l_s1[1];
		pa_n[2] = q_s1[2] * l_s1[0];
		pa_n[3] = q_s1[0] * l_s1[2];
		pa_n[4] = q_s1[0] * l_s1[1];
		pa_n[5] = q_s1[1] * l_s1[0];
		pb_n[0] = g_s1[1] * p_s1[2];
		pb_n[1] = g_s1[2] * p_s1[1];
		pb_n[2] = g_s1[2] * p_s1[0];
		pb_n[3] = g_s1[0] * p_s1[2];
		pb_n[4] = g_s1[0] * p_s1[1];
		pb_n[5] = g_s1[1] * p_s1[0];
	end

	// subtract the term pairs
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			n1_n[i] = NW'(pa_s2[2*i]) - NW'(pa_s2[2*i+1]);
			n2_n[i] = NW'(pb_s2[2*i]) - NW'(pb_s2[2*i+1]);
		end
	end

	// OR the magnitudes: same bit length as the largest one
	always_comb begin
		m1_n = '0;
		m2_n = '0;
		for (int i = 0; i < 3; i++) begin
			a1 = n1_s3[i][NW-1] ? NW'(-n1_s3[i]) : NW'(n1_s3[i]);
			a2 = n2_s3[i][NW-1] ? NW'(-n2_s3[i]) : NW'(n2_s3[i]);
			m1_n = m1_n | a1;
			m2_n = m2_n | a2;
		end
	end

	// find the bit length of each mask
	always_comb begin
		b1_n = '0;
		b2_n = '0;
		for (int k = 0; k < NW; k++) begin
			if (m1_s4[k]) b1_n = BLW'(k + 1);
			if (m2_s4[k]) b2_n = BLW'(k + 1);
		end
	end

	// bring each normal to a 29-bit magnitude
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (b1_s5 > BLW'(NORM_BITS)) t1 = n1_s5[i] >>> (b1_s5 - BLW'(NORM_BITS));
			else t1 = n1_s5[i] <<< (BLW'(NORM_BITS) - b1_s5);
			if (b2_s5 > BLW'(NORM_BITS)) t2 = n2_s5[i] >>> (b2_s5 - BLW'(NORM_BITS));
			else t2 = n2_s5[i] <<< (BLW'(NORM_BITS) - b2_s5);
			n1_sc[i] = NRM_W'(t1);
			n2_sc[i] = NRM_W'(t2);
		end
	end

	// advance the control bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
		end else if (en) begin
			ctl_s1 <= '{valid: valid_i, zero: 1'b0, neg: 1'b0};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= '{valid: ctl_s3.valid, zero: 1'b0, neg: 1'b0};
			ctl_s5 <= '{valid: ctl_s4.valid, zero: (m1_s4 == '0) || (m2_s4 == '0),
				neg: 1'b0};
			ctl_s6 <= ctl_s5;
		end
	end

	// advance the data
	always_ff @(posedge clk) begin
		if (en) begin
			q_s1  <= q_n;
			l_s1  <= l_n;
			g_s1  <= g_n;
			p_s1  <= p_n;
			pa_s2 <= pa_n;
			pb_s2 <= pb_n;
			for (int i = 0; i < 3; i++) g_s2[i] <= G_W'(g_s1[i]);
			n1_s3 <= n1_n;
			n2_s3 <= n2_n;
			g_s3  <= g_s2;
			n1_s4 <= n1_s3;
			n2_s4 <= n2_s3;
			m1_s4 <= m1_n;
			m2_s4 <= m2_n;
			g_s4  <= g_s3;
			n1_s5 <= n1_s4;
			n2_s5 <= n2_s4;
			b1_s5 <= b1_n;
			b2_s5 <= b2_n;
			g_s5  <= g_s4;
			n1_s6 <= n1_sc;
			n2_s6 <= n2_sc;
			g_s6  <= g_s5;
		end
	end

	assign ctl_o = ctl_s6;
	assign n1_o  = n1_s6;
	assign n2_o  = n2_s6;
	assign g_o   = g_s6;

endmodule

@@ rtl/paa_ops.sv @@
// Angle operands: sign test, n1 x n2 and n1.n2, common scaling, sum of squares.
// Seven register stages. Depends on paa_pkg.
module paa_ops
	import paa_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  ctl_t                    ctl_i,
	input  logic signed [NRM_W-1:0] n1_i [3],
	input  logic signed [NRM_W-1:0] n2_i [3],
	input  logic signed [G_W-1:0]   g_i  [3],
	output ctl_t                    ctl_o,
	output logic        [SQ_W-1:0]  sum_o,
	output logic signed [OPR_W-1:0] x_o
);

	localparam int PROD_W = 2 * NRM_W;
	localparam int C_W    = PROD_W + 1;
	localparam int D_W    = PROD_W + 2;
	localparam int DG_W   = NRM_W + G_W;
	localparam int DS_W   = DG_W + 2;
	localparam int BL_W   = $clog2(D_W + 1);

	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7;

	logic signed [DG_W-1:0]   dg_s1 [3];
	logic signed [PROD_W-1:0] cp_s1 [6], dp_s1 [3];
	logic signed [C_W-1:0]    c_s2 [3], c_s3 [3], c_s4 [3];
	logic signed [D_W-1:0]    d_s2, d_s3, d_s4;
	logic        [D_W-1:0]    m_s3;
	logic        [BL_W-1:0]   j_s4;
	logic signed [OPR_W-1:0]  cs_s5 [3], x_s5, x_s6, x_s7;
	logic        [SQ_W-1:0]   sq_s6 [3], sum_s7;

	logic signed [DG_W-1:0]   dg_n [3];
	logic signed [PROD_W-1:0] cp_n [6], dp_n [3];
	logic signed [C_W-1:0]    c_n [3];
	logic signed [D_W-1:0]    d_n;
	logic signed [DS_W-1:0]   dot_g;
	logic        [D_W-1:0]    m_n, a;
	logic        [BL_W-1:0]   bl, j_n;
	logic signed [OPR_W-1:0]  cs_n [3], x_n;
	logic        [OPR_W-1:0]  am;
	logic        [SQ_W-1:0]   sq_n [3];

	// multiply for n1.g, n1 x n2 and n1.n2
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dg_n[i] = n1_i[i] * g_i[i];
			dp_n[i] = n1_i[i] * n2_i[i];
		end
		cp_n[0] = n1_i[1] * n2_i[2];
		cp_n[1] = n1_i[2] * n2_i[1];
		cp_n[2] = n1_i[2] * n2_i[0];
		cp_n[3] = n1_i[0] * n2_i[2];
		cp_n[4] = n1_i[0] * n2_i[1];
		cp_n[5] = n1_i[1] * n2_i[0];
	end

	// sum the terms
	always_comb begin
		dot_g = DS_W'(dg_s1[0]) + DS_W'(dg_s1[1]) + DS_W'(dg_s1[2]);
		d_n   = D_W'(dp_s1[0]) + D_W'(dp_s1[1]) + D_W'(dp_s1[2]);
		for (int i = 0; i < 3; i++)
			c_n[i] = C_W'(cp_s1[2*i]) - C_W'(cp_s1[2*i+1]);
	end

	// OR the magnitudes of d and the parts of c
	always_comb begin
		m_n = d_s2[D_W-1] ? D_W'(-d_s2) : D_W'(d_s2);
		for (int i = 0; i < 3; i++) begin
			a   = c_s2[i][C_W-1] ? D_W'(-D_W'(c_s2[i])) : D_W'(c_s2[i]);
			m_n = m_n | a;
		end
	end

	// find the common right shift
	always_comb begin
		bl = '0;
		for (int k = 0; k < D_W; k++)
			if (m_s3[k]) bl = BL_W'(k + 1);
		j_n = (bl > BL_W'(OPER_BITS)) ? bl - BL_W'(OPER_BITS) : '0;
	end

	// scale the operands
	always_comb begin
		for (int i = 0; i < 3; i++)
			cs_n[i] = OPR_W'(c_s4[i] >>> j_s4);
		x_n = OPR_W'(d_s4 >>> j_s4);
	end

	// square the cross product parts
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			am      = cs_s5[i][OPR_W-1] ? OPR_W'(-cs_s5[i]) : OPR_W'(cs_s5[i]);
			sq_n[i] = SQ_W'(am) * SQ_W'(am);
		end
	end

	// advance the control bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
			ctl_s2 <= '{valid: ctl_s1.valid, zero: ctl_s1.zero, neg: dot_g[DS_W-1]};
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
		end
	end

	// advance the data
	always_ff @(posedge clk) begin
		if (en) begin
			dg_s1  <= dg_n;
			cp_s1  <= cp_n;
			dp_s1  <= dp_n;
			c_s2   <= c_n;
			d_s2   <= d_n;
			c_s3   <= c_s2;
			d_s3   <= d_s2;
			m_s3   <= m_n;
			c_s4   <= c_s3;
			d_s4   <= d_s3;
			j_s4   <= j_n;
			cs_s5  <= cs_n;
			x_s5   <= x_n;
			sq_s6  <= sq_n;
			x_s6   <= x_s5;
			sum_s7 <= sq_s6[0] + sq_s6[1] + sq_s6[2];
			x_s7   <= x_s6;
		end
	end

	assign ctl_o = ctl_s7;
	assign sum_o = sum_s7;
	assign x_o   = x_s7;

endmodule

@@ rtl/paa_isqrt.sv @@
// Pipelined integer square root, one result bit per register stage.
// Depends on paa_pkg.
module paa_isqrt
	import paa_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  ctl_t                    ctl_i,
	input  logic        [SQ_W-1:0]  sum_i,
	input  logic signed [OPR_W-1:0] x_i,
	output ctl_t                    ctl_o,
	output logic        [ROOT_W-1:0] root_o,
	output logic signed [OPR_W-1:0] x_o
);

	localparam int RM_W = ROOT_W + 4;

	ctl_t                    ctl_s  [ROOT_W+1];
	logic        [SQ_W-1:0]  n_s    [ROOT_W+1];
	logic        [RM_W-1:0]  rem_s  [ROOT_W+1];
	logic        [ROOT_W-1:0] root_s [ROOT_W+1];
	logic signed [OPR_W-1:0] x_s    [ROOT_W+1];

	assign ctl_s[0]  = ctl_i;
	assign n_s[0]    = sum_i;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign x_s[0]    = x_i;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_step
		logic [RM_W-1:0] acc, trial;

		// bring down the next bit pair and try the next root bit
		always_comb begin
			acc   = {rem_s[k][RM_W-3:0], n_s[k][SQ_W-1-2*k -: 2]};
			trial = RM_W'({root_s[k], 2'b01});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else if (en) begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[k+1] <= n_s[k];
				x_s[k+1] <= x_s[k];
				if (acc >= trial) begin
					rem_s[k+1]  <= acc - trial;
					root_s[k+1] <= {root_s[k][ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[k+1]  <= acc;
					root_s[k+1] <= {root_s[k][ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign ctl_o  = ctl_s[ROOT_W];
	assign root_o = root_s[ROOT_W];
	assign x_o    = x_s[ROOT_W];

endmodule

@@ rtl/paa_cordic.sv @@
// Pipelined vectoring rotation for atan2, then rounding, clamp and sign.
// One quadrant stage, one stage per rotation step, one output stage. Depends on paa_pkg.
module paa_cordic
	import paa_pkg::*;
#(
	parameter int ANGLE_FRAC = 14
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  ctl_t                     ctl_i,
	input  logic        [ROOT_W-1:0] y_i,
	input  logic signed [OPR_W-1:0]  x_i,
	output ctl_t                     ctl_o,
	output logic signed [PHI_W-1:0]  phi_o
);

	localparam int     SH       = 30 - ANGLE_FRAC;
	localparam longint RND_L    = 64'sd1 <<< (29 - ANGLE_FRAC);
	localparam longint PMAX_L   = (PI_Q30 + RND_L) >>> SH;
	localparam logic signed [Z_W-1:0] RND_Z  = Z_W'(RND_L);
	localparam logic signed [Z_W-1:0] PMAX_Z = Z_W'(PMAX_L);

	ctl_t                    ctl_s [CORDIC_STEPS+1];
	logic signed [CRD_W-1:0] x_s   [CORDIC_STEPS+1];
	logic signed [CRD_W-1:0] y_s   [CORDIC_STEPS+1];
	logic signed [Z_W-1:0]   z_s   [CORDIC_STEPS+1];
	ctl_t                    ctl_q;
	logic signed [PHI_W-1:0] phi_q;

	logic signed [CRD_W-1:0] sx, sy;
	logic signed [Z_W-1:0]   rz, mg;
	logic signed [PHI_W-1:0] phi_n;

	// fold the left half plane onto the right one
	always_comb begin
		sx = CRD_W'(x_i);
		sy = CRD_W'({1'b0, y_i});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (en) begin
			ctl_s[0] <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sx[CRD_W-1]) begin
				x_s[0] <= sy;
				y_s[0] <= -sx;
				z_s[0] <= Z_W'(HALF_PI_Q30);
			end else begin
				x_s[0] <= sx;
				y_s[0] <= sy;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
		logic pos;

		assign pos = !y_s[k][CRD_W-1] && (y_s[k] != '0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else if (en) begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end

		// rotate toward the x axis and accumulate the angle
		always_ff @(posedge clk) begin
			if (en) begin
				if (pos) begin
					x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] + Z_W'(ATAN_Q30[k]);
				end else begin
					x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] - Z_W'(ATAN_Q30[k]);
				end
			end
		end
	end

	// round to the output scale, clamp to [0, pi], apply sign; zero when a normal vanished
	always_comb begin
		rz = (z_s[CORDIC_STEPS] + RND_Z) >>> SH;
		if (rz[Z_W-1]) mg = '0;
		else if (rz > PMAX_Z) mg = PMAX_Z;
		else mg = rz;
		if (ctl_s[CORDIC_STEPS].zero) phi_n = '0;
		else if (ctl_s[CORDIC_STEPS].neg) phi_n = PHI_W'(-mg);
		else phi_n = PHI_W'(mg);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_s[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			phi_q <= phi_n;
		end
	end

	assign ctl_o = ctl_q;
	assign phi_o = phi_q;

endmodule

@@ rtl/plane_azimuth_angle.sv @@
// Signed azimuthal angle between the lepton scattering plane and the
// real photon production plane.
//
// Input channel: in_valid / in_stall with the four momentum vectors; a
// request is taken at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with phi (radians, ANGLE_FRAC
// fraction bits); a result leaves at an edge with out_valid high and
// out_stall low. Results come out in request order, one per request.
// Configuration: cfg_valid / cfg_ready writes sim_mode; cfg_ready is always
// high. Write it only while no request is in flight.
// Throughput: one request per cycle while no result is held at the output. The
// pipeline has 6 normal stages, 7 operand stages, 31 square root stages and
// 32 rotation and rounding stages.
// Stall: while a result waits at the output with out_stall high, the whole
// pipeline holds and in_stall is raised; nothing is dropped or repeated.
// Reset (arst_n low) empties the pipeline and clears sim_mode.
// Depends on paa_pkg, paa_front, paa_ops, paa_isqrt, paa_cordic.
module plane_azimuth_angle
	import paa_pkg::*;
#(
	parameter int COMP_WIDTH = 24,
	parameter int ANGLE_FRAC = 14
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COMP_WIDTH-1:0] in_x,
	input  logic signed [COMP_WIDTH-1:0] in_y,
	input  logic signed [COMP_WIDTH-1:0] in_z,
	input  logic signed [COMP_WIDTH-1:0] out_x,
	input  logic signed [COMP_WIDTH-1:0] out_y,
	input  logic signed [COMP_WIDTH-1:0] out_z,
	input  logic signed [COMP_WIDTH-1:0] prot_x,
	input  logic signed [COMP_WIDTH-1:0] prot_y,
	input  logic signed [COMP_WIDTH-1:0] prot_z,
	input  logic signed [COMP_WIDTH-1:0] phot_x,
	input  logic signed [COMP_WIDTH-1:0] phot_y,
	input  logic signed [COMP_WIDTH-1:0] phot_z,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [PHI_W-1:0]      phi
);

	logic sim_mode_q;
	logic en;

	logic signed [COMP_WIDTH-1:0] in_v [3], out_v [3], prot_v [3], phot_v [3];

	ctl_t                    ctl_f, ctl_o, ctl_r, ctl_c;
	logic signed [NRM_W-1:0] n1 [3], n2 [3];
	logic signed [G_W-1:0]   g [3];
	logic        [SQ_W-1:0]  sum;
	logic signed [OPR_W-1:0] x_o, x_r;
	logic        [ROOT_W-1:0] root;

	// hold the mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sim_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			sim_mode_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;

	// advance the pipeline unless a finished result is held
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	assign in_v   = '{in_x, in_y, in_z};
	assign out_v  = '{out_x, out_y, out_z};
	assign prot_v = '{prot_x, prot_y, prot_z};
	assign phot_v = '{phot_x, phot_y, phot_z};

	paa_front #(
		.COMP_WIDTH(COMP_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.sim_mode(sim_mode_q),
		.valid_i (in_valid),
		.in_v    (in_v),
		.out_v   (out_v),
		.prot_v  (prot_v),
		.phot_v  (phot_v),
		.ctl_o   (ctl_f),
		.n1_o    (n1),
		.n2_o    (n2),
		.g_o     (g)
	);

	paa_ops u_ops (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.ctl_i (ctl_f),
		.n1_i  (n1),
		.n2_i  (n2),
		.g_i   (g),
		.ctl_o (ctl_o),
		.sum_o (sum),
		.x_o   (x_o)
	);

	paa_isqrt u_isqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.ctl_i (ctl_o),
		.sum_i (sum),
		.x_i   (x_o),
		.ctl_o (ctl_r),
		.root_o(root),
		.x_o   (x_r)
	);

	paa_cordic #(
		.ANGLE_FRAC(ANGLE_FRAC)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.ctl_i (ctl_r),
		.y_i   (root),
		.x_i   (x_r),
		.ctl_o (ctl_c),
		.phi_o (phi)
	);

	assign out_valid = ctl_c.valid;

endmodule

@@ bench/tb.sv @@
// Testbench for plane_azimuth_angle: drives event requests with random idling,
// predicts phi with its own fixed-point model and checks each result in order.
// Depends on paa_pkg and the plane_azimuth_angle RTL.
`timescale 1ns / 100ps

module tb;
	import paa_pkg::*;

	localparam int CW = 24;
	localparam int AF = 14;
	localparam int LATENCY = 76;
	localparam int HOLD_LEN = 200;

	localparam longint ATAN_TAB [CORDIC_STEPS] = '{
		843314856, 497837829, 263043836, 133525158, 67021686,
		33543515, 16775850, 8388437, 4194282, 2097149,
		1048575, 524287, 262143, 131071, 65535,
		32767, 16383, 8191, 4095, 2047,
		1023, 511, 255, 127, 63,
		31, 15, 8, 4, 2
	};

	typedef logic signed [CW-1:0] comp_t;
	typedef struct {
		comp_t v [12]; // in xyz, out xyz, prot xyz, phot xyz
	} event_t;

	logic clk;
	logic arst_n;
	logic cfg_valid, cfg_ready, cfg_data;
	logic in_valid, in_stall;
	comp_t in_x, in_y, in_z, out_x, out_y, out_z;
	comp_t prot_x, prot_y, prot_z, phot_x, phot_y, phot_z;
	logic out_valid, out_stall;
	logic signed [PHI_W-1:0] phi;

	logic flip_lepton;
	logic signed [PHI_W-1:0] phi_queue [$];
	int errors;
	int send_idle_pct, recv_stall_pct;
	int hold_req;
	int hold_seen;
	int hold_cycles;

	plane_azimuth_angle #(.COMP_WIDTH(CW), .ANGLE_FRAC(AF)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.in_x(in_x), .in_y(in_y), .in_z(in_z),
		.out_x(out_x), .out_y(out_y), .out_z(out_z),
		.prot_x(prot_x), .prot_y(prot_y), .prot_z(prot_z),
		.phot_x(phot_x), .phot_y(phot_y), .phot_z(phot_z),
		.out_valid(out_valid), .out_stall(out_stall), .phi(phi)
	);

	always begin
		clk = 1'b0; #10;
		clk = 1'b1; #10;
	end

	// floor shift of a signed value
	function automatic longint asr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint absval(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic int bit_length(longint m);
		int b;
		b = 0;
		while (m != 0) begin
			b++;
			m = m >> 1;
		end
		return b;
	endfunction

	function automatic void cross3(input longint a [3], input longint b [3],
			output longint r [3]);
		r[0] = a[1] * b[2] - a[2] * b[1];
		r[1] = a[2] * b[0] - a[0] * b[2];
		r[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	function automatic void normalize(ref longint v [3]);
		longint m;
		int b;
		m = absval(v[0]);
		if (absval(v[1]) > m) m = absval(v[1]);
		if (absval(v[2]) > m) m = absval(v[2]);
		b = bit_length(m);
		for (int i = 0; i < 3; i++)
			v[i] = (b > NORM_BITS) ? asr(v[i], b - NORM_BITS) : v[i] <<< (NORM_BITS - b);
	endfunction

	function automatic longint int_sqrt(longint n);
		longint r, bt;
		r = 0;
		bt = 64'sd1 <<< 62;
		while (bt > n) bt = bt >> 2;
		while (bt != 0) begin
			if (n >= r + bt) begin
				n = n - (r + bt);
				r = (r >> 1) + bt;
			end else begin
				r = r >> 1;
			end
			bt = bt >> 2;
		end
		return r;
	endfunction

	// angle in Q30 by vectoring rotation
	function automatic longint vector_angle(longint x, longint y);
		longint z, nx, ny;
		z = 0;
		if (x < 0) begin
			nx = y; y = -x; x = nx; z = HALF_PI_Q30;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (y > 0) begin
				nx = x + asr(y, i); ny = y - asr(x, i); z += ATAN_TAB[i];
			end else begin
				nx = x - asr(y, i); ny = y + asr(x, i); z -= ATAN_TAB[i];
			end
			x = nx; y = ny;
		end
		return z;
	endfunction

	function automatic logic signed [PHI_W-1:0] plane_angle(event_t e, logic flip);
		longint q [3], l [3], g [3], p [3], n1 [3], n2 [3], c [3];
		longint d, m, sum, t, ang, pmax, res;
		int b, j;
		logic neg;
		for (int i = 0; i < 3; i++) begin
			q[i] = longint'(e.v[i]) - longint'(e.v[3+i]);
			l[i] = flip ? -longint'(e.v[i]) : longint'(e.v[i]);
			p[i] = e.v[6+i];
			g[i] = e.v[9+i];
		end
		cross3(q, l, n1);
		cross3(g, p, n2);
		if ((n1[0] == 0 && n1[1] == 0 && n1[2] == 0) ||
				(n2[0] == 0 && n2[1] == 0 && n2[2] == 0))
			return '0;
		normalize(n1);
		normalize(n2);
		neg = (n1[0] * g[0] + n1[1] * g[1] + n1[2] * g[2]) < 0;
		cross3(n1, n2, c);
		d = n1[0] * n2[0] + n1[1] * n2[1] + n1[2] * n2[2];
		m = absval(d);
		for (int i = 0; i < 3; i++)
			if (absval(c[i]) > m) m = absval(c[i]);
		b = bit_length(m);
		j = b > OPER_BITS ? b - OPER_BITS : 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			t = absval(asr(c[i], j));
			sum += t * t;
		end
		ang = vector_angle(asr(d, j), int_sqrt(sum));
		res = asr(ang + (64'sd1 <<< (29 - AF)), 30 - AF);
		pmax = asr(PI_Q30 + (64'sd1 <<< (29 - AF)), 30 - AF);
		if (res < 0) res = 0;
		if (res > pmax) res = pmax;
		if (neg) res = -res;
		return res[PHI_W-1:0];
	endfunction

	// send one request and queue its expected angle
	task automatic send_event(event_t e);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		{in_x, in_y, in_z} <= {e.v[0], e.v[1], e.v[2]};
		{out_x, out_y, out_z} <= {e.v[3], e.v[4], e.v[5]};
		{prot_x, prot_y, prot_z} <= {e.v[6], e.v[7], e.v[8]};
		{phot_x, phot_y, phot_z} <= {e.v[9], e.v[10], e.v[11]};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		phi_queue = {phi_queue, plane_angle(e, flip_lepton)};
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (phi_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_sim_mode(logic val);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		flip_lepton = val;
	endtask

	// random vector component with varied magnitude
	function automatic comp_t rand_comp();
		int sh;
		sh = $urandom_range(CW - 1);
		return comp_t'($urandom) >>> sh;
	endfunction

	function automatic event_t rand_event();
		event_t e;
		int kind;
		kind = $urandom_range(9);
		for (int i = 0; i < 12; i++) e.v[i] = (kind < 7) ? rand_comp() : comp_t'($urandom);
		// degenerate geometry now and then
		if (kind == 7) for (int i = 0; i < 3; i++) e.v[3+i] = e.v[i];
		if (kind == 8) for (int i = 0; i < 3; i++) e.v[6+i] = e.v[9+i];
		if (kind == 9 && $urandom_range(1)) for (int i = 0; i < 3; i++) e.v[i] = '0;
		return e;
	endfunction

	task automatic test_directed();
		event_t e;
		comp_t ext [4];
		ext = '{comp_t'(-8388608), comp_t'(8388607), comp_t'(0), comp_t'(4096)};
		send_idle_pct = 0;
		// all zero: both normals vanish
		for (int i = 0; i < 12; i++) e.v[i] = '0;
		send_event(e);
		// textbook geometry: beam along z, planes at right angles, parallel and opposite
		e.v = '{0, 0, 40960, 4096, 0, 36864, 0, 4096, 0, 0, 4096, 4096};
		send_event(e);
		e.v = '{0, 0, 40960, 4096, 0, 36864, 0, -4096, 0, 4096, 0, 4096};
		send_event(e);
		e.v = '{0, 0, 40960, 4096, 0, 36864, 4096, 0, 0, -4096, 0, 4096};
		send_event(e);
		e.v = '{0, 0, 40960, 4096, 0, 36864, -4096, 0, 0, 4096, 0, 4096};
		send_event(e);
		// parallel photon and proton: zero second normal
		e.v = '{0, 0, 40960, 4096, 0, 36864, 4096, 4096, 0, 8192, 8192, 0};
		send_event(e);
		// field extremes
		for (int k = 0; k < 12; k++) begin
			for (int i = 0; i < 12; i++) e.v[i] = ext[(i + k) % 4];
			e.v[k] = ext[k % 2];
			send_event(e);
		end
		for (int i = 0; i < 12; i++) e.v[i] = comp_t'(-8388608) >>> (i % 3);
		e.v[1] = 8388607;
		send_event(e);
	endtask

	task automatic test_random(int count, int idle, int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		repeat (count) send_event(rand_event());
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req++;
		repeat (150) send_event(rand_event());
	endtask

	// receiver stall, with a counted long hold when requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_cycles <= 0;
			hold_seen <= 0;
		end else if (hold_seen != hold_req) begin
			out_stall <= 1'b1;
			hold_cycles <= HOLD_LEN - 1;
			hold_seen <= hold_req;
		end else if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// compare each result with the oldest expected angle
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (phi_queue.size() == 0) begin
				$display("%0t: unexpected phi %0d", $time, phi);
				errors++;
			end else begin
				if (phi !== phi_queue[0]) begin
					$display("%0t: phi mismatch expected %0d actual %0d",
						$time, phi_queue[0], phi);
					errors++;
				end
				void'(phi_queue.pop_front());
			end
		end
	end

	initial begin
		errors = 0;
		flip_lepton = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		in_valid = 1'b0;
		{in_x, in_y, in_z, out_x, out_y, out_z} = '0;
		{prot_x, prot_y, prot_z, phot_x, phot_y, phot_z} = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(250, 0, 0);
		write_sim_mode(1'b1);
		test_directed();
		test_random(250, 59, 0);
		test_random(250, 0, 59);
		write_sim_mode(1'b0);
		test_random(250, 22, 22);
		test_backpressure();
		write_sim_mode(1'b1);
		test_random(200, 22, 22);
		drain();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#5ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
